// ===== src/msp_pkg.sv =====
package msp_pkg;

    localparam int CW = 32;
    localparam int PW = CW + 2;
    localparam int DW = PW + 1;
    localparam int XW = 2 * DW + 1;
    localparam int NTRACE = 4;
    localparam int NORIENT = 11;

    typedef struct packed {
        logic signed [PW-1:0] x;
        logic signed [PW-1:0] y;
    } pt_t;

    typedef struct packed {
        logic                 deg;
        logic signed [XW-1:0] d;
        logic signed [XW-1:0] n1;
        logic signed [XW-1:0] n2;
    } xing_t;

    // point slots per trace: 0..3 quad corners, 4 the trace start point
    localparam logic [2:0] S_IDX [NORIENT] = '{3'd0, 3'd1, 3'd2, 3'd0, 3'd1, 3'd2, 3'd3,
                                               3'd1, 3'd2, 3'd3, 3'd0};
    localparam logic [2:0] E_IDX [NORIENT] = '{3'd1, 3'd2, 3'd3, 3'd1, 3'd2, 3'd3, 3'd0,
                                               3'd0, 3'd1, 3'd2, 3'd3};
    localparam logic [2:0] P_IDX [NORIENT] = '{3'd2, 3'd3, 3'd0, 3'd4, 3'd4, 3'd4, 3'd4,
                                               3'd4, 3'd4, 3'd4, 3'd4};

endpackage

// ===== src/msp_orient.sv =====
module msp_orient (
    input  logic           aclk,
    input  logic           en,
    input  msp_pkg::pt_t   s,
    input  msp_pkg::pt_t   e,
    input  msp_pkg::pt_t   p,
    output logic           left
);
    import msp_pkg::*;

    logic signed [DW-1:0]   ex_reg, ey_reg, px_reg, py_reg;
    logic                   deg1_reg, deg2_reg;
    logic signed [2*DW-1:0] m1_reg, m2_reg;
    logic signed [XW-1:0]   cr;
    logic                   left_reg;

    assign cr = $signed({m1_reg[2*DW-1], m1_reg}) - $signed({m2_reg[2*DW-1], m2_reg});

    always_ff @(posedge aclk) begin
        if (en) begin
            ex_reg   <= $signed({e.x[PW-1], e.x}) - $signed({s.x[PW-1], s.x});
            ey_reg   <= $signed({e.y[PW-1], e.y}) - $signed({s.y[PW-1], s.y});
            px_reg   <= $signed({p.x[PW-1], p.x}) - $signed({s.x[PW-1], s.x});
            py_reg   <= $signed({p.y[PW-1], p.y}) - $signed({s.y[PW-1], s.y});
            deg1_reg <= (s.x == e.x) && (s.y == e.y);
            m1_reg   <= ex_reg * py_reg;
            m2_reg   <= ey_reg * px_reg;
            deg2_reg <= deg1_reg;
            left_reg <= deg2_reg || (!cr[XW-1] && (cr != '0));
        end
    end

    assign left = left_reg;

endmodule

// ===== src/msp_xing.sv =====
module msp_xing (
    input  logic           aclk,
    input  logic           en,
    input  msp_pkg::pt_t   l1s,
    input  msp_pkg::pt_t   l1e,
    input  msp_pkg::pt_t   l2s,
    input  msp_pkg::pt_t   l2e,
    output msp_pkg::xing_t res
);
    import msp_pkg::*;

    logic signed [DW-1:0]   ux_reg, uy_reg, vx_reg, vy_reg, wx_reg, wy_reg;
    logic                   deg1_reg, deg2_reg;
    logic signed [2*DW-1:0] uv1_reg, uv2_reg, uw1_reg, uw2_reg, vw1_reg, vw2_reg;
    xing_t                  res_reg;

    function automatic logic signed [XW-1:0] sub_ext(logic signed [2*DW-1:0] a,
                                                     logic signed [2*DW-1:0] b);
        return $signed({a[2*DW-1], a}) - $signed({b[2*DW-1], b});
    endfunction

    always_ff @(posedge aclk) begin
        if (en) begin
            ux_reg   <= $signed({l1e.x[PW-1], l1e.x}) - $signed({l1s.x[PW-1], l1s.x});
            uy_reg   <= $signed({l1e.y[PW-1], l1e.y}) - $signed({l1s.y[PW-1], l1s.y});
            vx_reg   <= $signed({l2e.x[PW-1], l2e.x}) - $signed({l2s.x[PW-1], l2s.x});
            vy_reg   <= $signed({l2e.y[PW-1], l2e.y}) - $signed({l2s.y[PW-1], l2s.y});
            wx_reg   <= $signed({l1s.x[PW-1], l1s.x}) - $signed({l2s.x[PW-1], l2s.x});
            wy_reg   <= $signed({l1s.y[PW-1], l1s.y}) - $signed({l2s.y[PW-1], l2s.y});
            deg1_reg <= ((l1s.x == l1e.x) && (l1s.y == l1e.y)) ||
                        ((l2s.x == l2e.x) && (l2s.y == l2e.y));
            uv1_reg  <= ux_reg * vy_reg;
            uv2_reg  <= uy_reg * vx_reg;
            uw1_reg  <= ux_reg * wy_reg;
            uw2_reg  <= uy_reg * wx_reg;
            vw1_reg  <= vx_reg * wy_reg;
            vw2_reg  <= vy_reg * wx_reg;
            deg2_reg <= deg1_reg;
            res_reg.deg <= deg2_reg;
            res_reg.d   <= sub_ext(uv1_reg, uv2_reg);
            res_reg.n1  <= sub_ext(uw1_reg, uw2_reg);
            res_reg.n2  <= sub_ext(vw1_reg, vw2_reg);
        end
    end

    assign res = res_reg;

endmodule

// ===== src/moving_segment_pair_intersect_top.sv =====
// moving segment pair intersection test
// input channel s_*: one word holds the eight packed points of two moving
//   segments a and b (x in bits 63..32, y in bits 31..0, signed)
// result channel m_*: one word with m_intersects, 1 when the two swept
//   trapeziums intersect
// the flag is the or of four endpoint-trace-in-quad tests and two strict
//   crossing tests of the initial and of the final segments, all exact
// throughput: one word per cycle while the receiver does not stall, with no dependence between words
// path from input accept to m_valid: the input register loads at the
//   accept edge, then difference, multiply and cross subtract stages, then
//   the result register
// reset clears all valid bits; no word is in flight after reset
// when the receiver stalls, the whole pipeline holds and s_ready drops;
//   nothing is lost or repeated, and words resume when m_ready returns
module moving_segment_pair_intersect_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_a_init_start,
    input  logic [63:0] s_a_init_end,
    input  logic [63:0] s_a_final_start,
    input  logic [63:0] s_a_final_end,
    input  logic [63:0] s_b_init_start,
    input  logic [63:0] s_b_init_end,
    input  logic [63:0] s_b_final_start,
    input  logic [63:0] s_b_final_end,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_intersects
);
    import msp_pkg::*;

    logic        en;
    logic [3:0]  v_reg;
    logic        m_valid_reg;
    logic        m_int_reg;
    pt_t         pt_reg [8];
    pt_t         pts [NTRACE][5];
    logic        ori [NTRACE][NORIENT];
    logic [NTRACE-1:0] hit;
    xing_t       xr [2];
    logic        xok [2];

    function automatic pt_t unpack(logic [63:0] w);
        pt_t r;
        r.x = PW'($signed(w[32+CW-1:32]));
        r.y = PW'($signed(w[CW-1:0]));
        return r;
    endfunction

    function automatic logic ratio_in(logic signed [XW-1:0] n, logic signed [XW-1:0] d);
        logic signed [XW:0] df;
        logic signed [XW:0] nd;
        logic               dpos, npos, nneg;
        df   = $signed({d[XW-1], d}) - $signed({n[XW-1], n});
        nd   = $signed({n[XW-1], n}) - $signed({d[XW-1], d});
        dpos = !d[XW-1] && (d != '0);
        npos = !n[XW-1] && (n != '0);
        nneg = n[XW-1];
        if (dpos) return npos && !df[XW] && (df != '0);
        return nneg && !nd[XW] && (nd != '0);
    endfunction

    function automatic pt_t shift_pt(pt_t f, pt_t p0, pt_t p1);
        pt_t r;
        r.x = f.x + p0.x - p1.x;
        r.y = f.y + p0.y - p1.y;
        return r;
    endfunction

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            v_reg       <= {v_reg[2:0], s_valid};
            m_valid_reg <= v_reg[3];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pt_reg[0] <= unpack(s_a_init_start);
            pt_reg[1] <= unpack(s_a_init_end);
            pt_reg[2] <= unpack(s_a_final_start);
            pt_reg[3] <= unpack(s_a_final_end);
            pt_reg[4] <= unpack(s_b_init_start);
            pt_reg[5] <= unpack(s_b_init_end);
            pt_reg[6] <= unpack(s_b_final_start);
            pt_reg[7] <= unpack(s_b_final_end);
            m_int_reg <= (|hit) || xok[0] || xok[1];
        end
    end

    // trace t: start point index, final point index, other segment base
    always_comb begin
        for (int t = 0; t < NTRACE; t++) begin
            automatic int p0i = (t < 2) ? t : t + 2;
            automatic int ob  = (t < 2) ? 4 : 0;
            pts[t][0] = pt_reg[ob];
            pts[t][1] = pt_reg[ob + 1];
            pts[t][2] = shift_pt(pt_reg[ob + 3], pt_reg[p0i], pt_reg[p0i + 2]);
            pts[t][3] = shift_pt(pt_reg[ob + 2], pt_reg[p0i], pt_reg[p0i + 2]);
            pts[t][4] = pt_reg[p0i];
        end
    end

    for (genvar t = 0; t < NTRACE; t++) begin : g_trace
        for (genvar k = 0; k < NORIENT; k++) begin : g_ori
            msp_orient u_orient (
                .aclk (aclk),
                .en   (en),
                .s    (pts[t][S_IDX[k]]),
                .e    (pts[t][E_IDX[k]]),
                .p    (pts[t][P_IDX[k]]),
                .left (ori[t][k])
            );
        end
        assign hit[t] = (ori[t][0] && ori[t][1] && ori[t][2]) ?
                        (ori[t][3] && ori[t][4] && ori[t][5] && ori[t][6]) :
                        (ori[t][7] && ori[t][8] && ori[t][9] && ori[t][10]);
    end

    for (genvar j = 0; j < 2; j++) begin : g_xing
        msp_xing u_xing (
            .aclk (aclk),
            .en   (en),
            .l1s  (pt_reg[2*j]),
            .l1e  (pt_reg[2*j + 1]),
            .l2s  (pt_reg[2*j + 4]),
            .l2e  (pt_reg[2*j + 5]),
            .res  (xr[j])
        );
        assign xok[j] = !xr[j].deg && (xr[j].d != '0) &&
                        ratio_in(xr[j].n1, xr[j].d) && ratio_in(xr[j].n2, xr[j].d);
    end

    assign m_valid      = m_valid_reg;
    assign m_intersects = m_int_reg;

`ifndef SYNTHESIS
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid && (v_reg == '0))
        else $error("valid bits not cleared by reset");
    a_stall_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !s_ready)
        else $error("input accepted while output stalled");
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (v_reg == $past(v_reg)) && m_valid)
        else $error("pipeline moved during stall");
    a_last_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        (en && v_reg[3]) |=> m_valid)
        else $error("word lost at output stage");
`endif

endmodule

// ===== test/moving_segment_pair_intersect_top_tb.sv =====
`timescale 1ns / 1ps

module moving_segment_pair_intersect_top_tb;

    typedef logic signed [127:0] wide_t;
    typedef struct {
        wide_t x;
        wide_t y;
    } vec_t;
    typedef logic [63:0] pair_t [8];

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [63:0] s_a_init_start = '0;
    logic [63:0] s_a_init_end = '0;
    logic [63:0] s_a_final_start = '0;
    logic [63:0] s_a_final_end = '0;
    logic [63:0] s_b_init_start = '0;
    logic [63:0] s_b_init_end = '0;
    logic [63:0] s_b_final_start = '0;
    logic [63:0] s_b_final_end = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_intersects;

    bit hit_q[$];
    int errors = 0;
    int stall_cycles = 0;
    int rdy_idle = 0;
    bit calm = 1'b0;

    moving_segment_pair_intersect_top uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_a_init_start(s_a_init_start), .s_a_init_end(s_a_init_end),
        .s_a_final_start(s_a_final_start), .s_a_final_end(s_a_final_end),
        .s_b_init_start(s_b_init_start), .s_b_init_end(s_b_init_end),
        .s_b_final_start(s_b_final_start), .s_b_final_end(s_b_final_end),
        .m_valid(m_valid), .m_ready(m_ready), .m_intersects(m_intersects)
    );

    always #4 aclk = ~aclk;

    function automatic vec_t unpk(logic [63:0] w);
        vec_t p;
        p.x = wide_t'($signed(w[63:32]));
        p.y = wide_t'($signed(w[31:0]));
        return p;
    endfunction

    function automatic logic [63:0] pk(int x, int y);
        return {x[31:0], y[31:0]};
    endfunction

    function automatic bit same(vec_t a, vec_t b);
        return a.x == b.x && a.y == b.y;
    endfunction

    function automatic wide_t crs(wide_t ax, wide_t ay, wide_t bx, wide_t by);
        return ax * by - ay * bx;
    endfunction

    function automatic bit is_left(vec_t s, vec_t e, vec_t p);
        if (same(s, e))
            return 1'b1;
        return crs(e.x - s.x, e.y - s.y, p.x - s.x, p.y - s.y) > 0;
    endfunction

    function automatic bit trace_in_quad(vec_t p0, vec_t p1, vec_t is, vec_t ie,
                                         vec_t fs, vec_t fe);
        vec_t q0, q1, q2, q3;
        q0 = is;
        q1 = ie;
        q2.x = fe.x + p0.x - p1.x;
        q2.y = fe.y + p0.y - p1.y;
        q3.x = fs.x + p0.x - p1.x;
        q3.y = fs.y + p0.y - p1.y;
        if (is_left(q0, q1, q2) && is_left(q1, q2, q3) && is_left(q2, q3, q0))
            return is_left(q0, q1, p0) && is_left(q1, q2, p0) &&
                   is_left(q2, q3, p0) && is_left(q3, q0, p0);
        return is_left(q1, q0, p0) && is_left(q2, q1, p0) &&
               is_left(q3, q2, p0) && is_left(q0, q3, p0);
    endfunction

    function automatic bit between01(wide_t n, wide_t d);
        if (d > 0)
            return n > 0 && d - n > 0;
        return n < 0 && n - d > 0;
    endfunction

    function automatic bit lines_cross(vec_t s1, vec_t e1, vec_t s2, vec_t e2);
        wide_t ux, uy, vx, vy, wx, wy, d;
        if (same(s1, e1) || same(s2, e2))
            return 1'b0;
        ux = e1.x - s1.x; uy = e1.y - s1.y;
        vx = e2.x - s2.x; vy = e2.y - s2.y;
        wx = s1.x - s2.x; wy = s1.y - s2.y;
        d = crs(ux, uy, vx, vy);
        if (d == 0)
            return 1'b0;
        return between01(crs(ux, uy, wx, wy), d) && between01(crs(vx, vy, wx, wy), d);
    endfunction

    function automatic bit sweep_hit(pair_t w);
        vec_t ais, aie, afs, afe, bis, bie, bfs, bfe;
        ais = unpk(w[0]); aie = unpk(w[1]); afs = unpk(w[2]); afe = unpk(w[3]);
        bis = unpk(w[4]); bie = unpk(w[5]); bfs = unpk(w[6]); bfe = unpk(w[7]);
        return trace_in_quad(ais, afs, bis, bie, bfs, bfe) ||
               trace_in_quad(aie, afe, bis, bie, bfs, bfe) ||
               trace_in_quad(bis, bfs, ais, aie, afs, afe) ||
               trace_in_quad(bie, bfe, ais, aie, afs, afe) ||
               lines_cross(ais, aie, bis, bie) || lines_cross(afs, afe, bfs, bfe);
    endfunction

    task automatic send_pair(pair_t w);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 13);
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_a_init_start = w[0]; s_a_init_end = w[1];
        s_a_final_start = w[2]; s_a_final_end = w[3];
        s_b_init_start = w[4]; s_b_init_end = w[5];
        s_b_final_start = w[6]; s_b_final_end = w[7];
        s_valid = 1'b1;
        forever begin
            @(posedge aclk);
            if (s_ready) break;
        end
        hit_q.push_back(sweep_hit(w));
        @(negedge aclk);
    endtask

    function automatic int rnd_coord(int mode);
        int ext [6] = '{32'sh7fffffff, 32'sh80000000, 0, -1, 1, 32'sh7ffffffe};
        case (mode)
            0: return int'($urandom);
            1: return $urandom_range(0, 40) - 20;
            2: return ext[$urandom_range(0, 5)];
            default: return ($urandom_range(0, 8) - 4) * 32'sh10000000;
        endcase
    endfunction

    function automatic pair_t rnd_pair();
        pair_t w;
        int mode;
        mode = $urandom_range(0, 9);
        mode = mode < 5 ? 1 : mode < 7 ? 0 : mode < 9 ? 2 : 3;
        foreach (w[i])
            w[i] = pk(rnd_coord(mode), rnd_coord(mode));
        if ($urandom_range(0, 7) == 0)
            w[$urandom_range(0, 7)] = w[$urandom_range(0, 7)];
        return w;
    endfunction

    task automatic test_directed();
        pair_t w;
        // all zero, fully degenerate
        foreach (w[i]) w[i] = '0;
        send_pair(w);
        foreach (w[i]) w[i] = '1;
        send_pair(w);
        // stationary crossing segments
        w = '{pk(-10, 0), pk(10, 0), pk(-10, 0), pk(10, 0),
              pk(0, -10), pk(0, 10), pk(0, -10), pk(0, 10)};
        send_pair(w);
        // parallel overlapping segments
        w = '{pk(0, 0), pk(10, 0), pk(0, 0), pk(10, 0),
              pk(5, 0), pk(15, 0), pk(5, 0), pk(15, 0)};
        send_pair(w);
        // parallel apart
        w = '{pk(0, 0), pk(10, 0), pk(0, 0), pk(10, 0),
              pk(0, 5), pk(10, 5), pk(0, 5), pk(10, 5)};
        send_pair(w);
        // a sweeps up through stationary b
        w = '{pk(-5, -20), pk(5, -20), pk(-5, 20), pk(5, 20),
              pk(-1, 0), pk(1, 0), pk(-1, 0), pk(1, 0)};
        send_pair(w);
        // degenerate a point inside b sweep
        w = '{pk(0, 5), pk(0, 5), pk(0, 5), pk(0, 5),
              pk(-10, 0), pk(10, 0), pk(-10, 10), pk(10, 10)};
        send_pair(w);
        // touching at endpoint only
        w = '{pk(0, 0), pk(10, 0), pk(0, 0), pk(10, 0),
              pk(10, 0), pk(10, 10), pk(10, 0), pk(10, 10)};
        send_pair(w);
        // extreme coordinates
        w = '{pk(32'sh80000000, 32'sh80000000), pk(32'sh7fffffff, 32'sh7fffffff),
              pk(32'sh7fffffff, 32'sh80000000), pk(32'sh80000000, 32'sh7fffffff),
              pk(32'sh80000000, 32'sh7fffffff), pk(32'sh7fffffff, 32'sh80000000),
              pk(32'sh80000000, 32'sh80000000), pk(32'sh7fffffff, 32'sh7fffffff)};
        send_pair(w);
        w = '{pk(32'sh7fffffff, 0), pk(32'sh80000000, 0), pk(0, 32'sh7fffffff),
              pk(0, 32'sh80000000), pk(0, 0), pk(1, 1), pk(-1, -1),
              pk(32'sh7fffffff, 32'sh7fffffff)};
        send_pair(w);
        // far apart, no hit
        w = '{pk(0, 0), pk(1, 0), pk(0, 1), pk(1, 1),
              pk(100, 100), pk(101, 100), pk(100, 101), pk(101, 101)};
        send_pair(w);
        // reversed orientation trapezium
        w = '{pk(10, 0), pk(-10, 0), pk(10, 10), pk(-10, 10),
              pk(0, 3), pk(0, 3), pk(0, 4), pk(0, 4)};
        send_pair(w);
    endtask

    task automatic test_random(int n);
        repeat (n) send_pair(rnd_pair());
    endtask

    task automatic test_drain_pause();
        test_random(20);
        s_valid = 1'b0;
        while (hit_q.size() != 0) @(negedge aclk);
        test_random(20);
    endtask

    task automatic test_no_idle(int n);
        calm = 1'b1;
        test_random(n);
        s_valid = 1'b0;
    endtask

    // receiver idles in bursts of random length
    always @(negedge aclk) begin
        if (calm) begin
            rdy_idle = 0;
            m_ready = 1'b1;
        end else if (rdy_idle != 0) begin
            rdy_idle--;
        end else if (m_ready && $urandom_range(0, 5) == 0) begin
            rdy_idle = $urandom_range(1, 13) - 1;
            m_ready = 1'b0;
        end else begin
            m_ready = 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (hit_q.size() == 0) begin
                $error("unexpected word: intersects actual %0d", m_intersects);
                errors++;
            end else begin
                if (m_intersects !== hit_q[0]) begin
                    $error("intersects expected %0d actual %0d", hit_q[0], m_intersects);
                    errors++;
                end
                void'(hit_q.pop_front());
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= 2000) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        repeat (7) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);
        test_directed();
        test_random(400);
        test_drain_pause();
        test_random(200);
        test_no_idle(100);
        while (hit_q.size() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
        if (errors == 0 && hit_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
